>>> sv/hxy_pkg.sv
package hxy_pkg;

	typedef logic [1:0] quad_t;

	localparam int CFG_INDEX_W = 2;
	localparam int COORD_W = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_X_OFFSET = 2'd0,
		REG_Y_OFFSET = 2'd1
	} cfg_reg_t;

	// Next state quadrant and coordinate bits, indexed by {quad, digit}
	localparam quad_t NEXT_QUAD [0:15] = '{
		2'd1, 2'd0, 2'd0, 2'd3, 2'd0, 2'd1, 2'd1, 2'd2,
		2'd3, 2'd2, 2'd2, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0
	};
	localparam logic [15:0] X_BITS = 16'h39C6;
	localparam logic [15:0] Y_BITS = 16'h936C;

endpackage

>>> sv/hxy_cell.sv
module hxy_cell #(
	parameter int IW = 32,
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  logic [IW-1:0]        up_idx,
	input  hxy_pkg::quad_t       up_quad,
	input  logic [CW-1:0]        up_x,
	input  logic [CW-1:0]        up_y,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output logic [IW-1:0]        dn_idx,
	output hxy_pkg::quad_t       dn_quad,
	output logic [CW-1:0]        dn_x,
	output logic [CW-1:0]        dn_y
);
	import hxy_pkg::*;

	logic          valid_q;
	logic [IW-1:0] idx_q;
	quad_t         quad_q;
	logic [CW-1:0] x_q;
	logic [CW-1:0] y_q;
	logic [3:0]    entry;
	logic          load;

	assign up_ready = !valid_q || dn_ready;
	assign load = up_valid && up_ready;
	assign entry = {up_quad, up_idx[IW-1 -: 2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q  <= up_idx << 2;
			quad_q <= NEXT_QUAD[entry];
			x_q    <= (up_x << 1) | CW'(X_BITS[entry]);
			y_q    <= (up_y << 1) | CW'(Y_BITS[entry]);
		end
	end

	assign dn_valid = valid_q;
	assign dn_idx   = idx_q;
	assign dn_quad  = quad_q;
	assign dn_x     = x_q;
	assign dn_y     = y_q;

endmodule

>>> sv/hilbert_index_to_xy.sv
// Hilbert curve index to grid point.
// Input channel: in_valid / in_stall with curve_index. A word is taken at a
// rising edge with in_valid high and in_stall low. Index bits at or above
// 2*CURVE_LEVELS are ignored.
// Output channel: out_valid / out_stall with x_coord and y_coord, the curve
// point plus the configured offsets, wrapping modulo 2^32.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// writes the x offset, index 1 the y offset, other indexes are dropped.
// cfg_ready is always high. Write only while no word is in flight.
// Each word passes through one cell per 2-bit digit, then the offset-add
// output register. Throughput is one word per cycle while out_stall is low.
// When the receiver stalls, the output register holds its word and the
// cells fill up behind it; in_stall rises once no cell can move.
// Reset clears all valid flags and both offsets to zero.
module hilbert_index_to_xy #(
	parameter int CURVE_LEVELS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hxy_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       curve_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [31:0]                x_coord,
	output logic signed [31:0]                y_coord
);
	import hxy_pkg::*;

	localparam int IW = 2 * CURVE_LEVELS;
	localparam int CW = CURVE_LEVELS;
	localparam quad_t START_QUAD = (CURVE_LEVELS % 2 == 1) ? 2'd1 : 2'd0;

	logic [COORD_W-1:0] x_offset_q;
	logic [COORD_W-1:0] y_offset_q;

	logic          c_valid [0:CURVE_LEVELS];
	logic          c_ready [0:CURVE_LEVELS];
	logic [IW-1:0] c_idx   [0:CURVE_LEVELS];
	quad_t         c_quad  [0:CURVE_LEVELS];
	logic [CW-1:0] c_x     [0:CURVE_LEVELS];
	logic [CW-1:0] c_y     [0:CURVE_LEVELS];

	logic               out_valid_q;
	logic [COORD_W-1:0] x_coord_q;
	logic [COORD_W-1:0] y_coord_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= '0;
			y_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_OFFSET: x_offset_q <= cfg_data;
				REG_Y_OFFSET: y_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	generate
		if (IW <= 32) begin : g_idx_fit
			assign c_idx[0] = curve_index[IW-1:0];
		end else begin : g_idx_pad
			assign c_idx[0] = IW'(curve_index);
		end
	endgenerate

	assign c_valid[0] = in_valid;
	assign c_quad[0]  = START_QUAD;
	assign c_x[0]     = '0;
	assign c_y[0]     = '0;
	assign in_stall   = !c_ready[0];

	genvar i;
	generate
		for (i = 0; i < CURVE_LEVELS; i++) begin : g_cell
			hxy_cell #(
				.IW(IW),
				.CW(CW)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.up_valid(c_valid[i]),
				.up_ready(c_ready[i]),
				.up_idx  (c_idx[i]),
				.up_quad (c_quad[i]),
				.up_x    (c_x[i]),
				.up_y    (c_y[i]),
				.dn_valid(c_valid[i+1]),
				.dn_ready(c_ready[i+1]),
				.dn_idx  (c_idx[i+1]),
				.dn_quad (c_quad[i+1]),
				.dn_x    (c_x[i+1]),
				.dn_y    (c_y[i+1])
			);
		end
	endgenerate

	assign c_ready[CURVE_LEVELS] = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (c_ready[CURVE_LEVELS]) begin
			out_valid_q <= c_valid[CURVE_LEVELS];
		end
	end

	always_ff @(posedge clk) begin
		if (c_ready[CURVE_LEVELS] && c_valid[CURVE_LEVELS]) begin
			x_coord_q <= COORD_W'(c_x[CURVE_LEVELS]) + x_offset_q;
			y_coord_q <= COORD_W'(c_y[CURVE_LEVELS]) + y_offset_q;
		end
	end

	assign out_valid = out_valid_q;
	assign x_coord   = x_coord_q;
	assign y_coord   = y_coord_q;

endmodule

>>> dv/hilbert_index_to_xy_checker.sv
`timescale 1ns / 1ps

module hilbert_index_to_xy_checker #(
	parameter int CURVE_LEVELS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [hxy_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [31:0]                     curve_index,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic signed [31:0]              x_coord,
	input  logic signed [31:0]              y_coord,
	output int                              fail_count,
	output int                              pending
);
	import hxy_pkg::*;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} point_t;

	localparam logic [3:0] WALK_NEXT [0:15] = '{
		4'd4, 4'd0, 4'd0, 4'd12, 4'd0, 4'd4, 4'd4, 4'd8,
		4'd12, 4'd8, 4'd8, 4'd4, 4'd8, 4'd12, 4'd12, 4'd0
	};
	localparam bit WALK_X [0:15] = '{
		1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
		1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0
	};
	localparam bit WALK_Y [0:15] = '{
		1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
		1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1
	};

	logic [31:0] x_origin;
	logic [31:0] y_origin;
	point_t      expected_points [$];
	point_t      want;
	int          errs;

	function automatic point_t hilbert_point(logic [31:0] idx, logic [31:0] xo,
			logic [31:0] yo);
		logic [63:0] wide;
		logic [3:0]  st;
		logic [3:0]  ent;
		logic [1:0]  digit;
		logic [31:0] x;
		logic [31:0] y;
		int          lvl;
		point_t      p;
		wide = {32'd0, idx};
		st = (CURVE_LEVELS % 2 == 1) ? 4'd4 : 4'd0;
		x = '0;
		y = '0;
		for (lvl = CURVE_LEVELS - 1; lvl >= 0; lvl--) begin
			digit = wide[2*lvl +: 2];
			ent = st + 4'(digit);
			x[lvl] = WALK_X[ent];
			y[lvl] = WALK_Y[ent];
			st = WALK_NEXT[ent];
		end
		p.x = x + xo;
		p.y = y + yo;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin = '0;
			y_origin = '0;
			expected_points.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_points.size() == 0) begin
					errs++;
					$error("result with no word outstanding: x_coord %0d y_coord %0d",
						x_coord, y_coord);
				end else begin
					want = expected_points.pop_front();
					if (x_coord !== want.x) begin
						errs++;
						$error("x_coord: expected %0d, got %0d", $signed(want.x), x_coord);
					end
					if (y_coord !== want.y) begin
						errs++;
						$error("y_coord: expected %0d, got %0d", $signed(want.y), y_coord);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_X_OFFSET: x_origin = cfg_data;
					REG_Y_OFFSET: y_origin = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_points = {expected_points,
					hilbert_point(curve_index, x_origin, y_origin)};
			pending <= expected_points.size();
			fail_count <= errs;
		end
	end

endmodule

>>> dv/hilbert_index_to_xy_tb.sv
`timescale 1ns / 1ps

module hilbert_index_to_xy_tb;
	import hxy_pkg::*;

	localparam int CURVE_LEVELS = 16;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 125;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [31:0]            curve_index;
	logic                   out_valid;
	logic                   out_stall;
	logic signed [31:0]     x_coord;
	logic signed [31:0]     y_coord;
	int                     fail_count;
	int                     pending;
	int                     quiet_cycles;
	bit                     quiet;

	logic [31:0] corner_words [0:11] = '{
		32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
		32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
		32'h0000_FFFF, 32'hFFFF_0000, 32'h4000_0000, 32'hC000_0000
	};
	logic [31:0] edge_words [0:3] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
	};

	hilbert_index_to_xy #(
		.CURVE_LEVELS(CURVE_LEVELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.curve_index(curve_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.x_coord(x_coord),
		.y_coord(y_coord)
	);

	hilbert_index_to_xy_checker #(
		.CURVE_LEVELS(CURVE_LEVELS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.curve_index(curve_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_word(input logic [31:0] idx);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		curve_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_words();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic write_offsets(input logic [31:0] xo, input logic [31:0] yo);
		write_reg(REG_X_OFFSET, xo);
		write_reg(REG_Y_OFFSET, yo);
	endtask

	function automatic logic [31:0] random_index();
		logic [31:0] r;
		logic [1:0]  dg;
		int          k;
		r = $urandom;
		dg = 2'($urandom_range(0, 3));
		k = $urandom_range(1, CURVE_LEVELS);
		case ($urandom_range(0, 9))
			5, 6: r = r & 32'((64'd1 << (2 * k)) - 64'd1);
			7: r = 32'((64'd1 << (2 * k)) - 64'($urandom_range(0, 3)));
			8: r = {16{dg}};
			9: r = 32'hFFFF_FFFF ^ (32'd1 << $urandom_range(0, 31));
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] random_offset();
		case ($urandom_range(0, 7))
			0: return 32'hC000_0000;
			1: return 32'h4000_0000;
			2: return 32'h0000_0000;
			default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
		endcase
	endfunction

	initial begin
		int gap;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$error("no handshake for %0d cycles", quiet_cycles);
			$display("hilbert_index_to_xy_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_X_OFFSET;
		cfg_data = '0;
		in_valid = 1'b0;
		curve_index = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_words[i]) send_word(corner_words[i]);
		drain_words();

		write_offsets(32'hC000_0000, 32'h4000_0000);
		cfg_valid <= 1'b0;
		foreach (edge_words[i]) send_word(edge_words[i]);
		drain_words();

		write_offsets(32'h4000_0000, 32'hC000_0000);
		write_reg(REG_SPARE_2, $urandom);
		write_reg(REG_SPARE_3, $urandom);
		cfg_valid <= 1'b0;
		foreach (edge_words[i]) send_word(edge_words[i]);
		drain_words();

		// wrap past the signed range
		write_offsets(32'h7FFF_FFFF, 32'h8000_0000);
		cfg_valid <= 1'b0;
		foreach (edge_words[i]) send_word(edge_words[i]);
		drain_words();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			quiet = (phase % 3 == 1);
			write_offsets(random_offset(), random_offset());
			if ($urandom_range(0, 1) == 1)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
			cfg_valid <= 1'b0;
			repeat (WORDS_PER_PHASE) send_word(random_index());
			drain_words();
		end
		quiet = 1'b0;

		repeat (CURVE_LEVELS + 4) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("hilbert_index_to_xy_tb passed");
		end else begin
			$display("hilbert_index_to_xy_tb failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/hxy_pkg.sv
sv/hxy_cell.sv
sv/hilbert_index_to_xy.sv
dv/hilbert_index_to_xy_checker.sv
dv/hilbert_index_to_xy_tb.sv
